@@ rtl/sorted_queue_merge_unit_assert.svh @@
// Assertion macros used by the sorted queue merge unit queue module.
`ifndef SORTED_QUEUE_MERGE_UNIT_ASSERT_SVH
`define SORTED_QUEUE_MERGE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SQM_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("sqm assertion failed");

// Next-cycle implication, checked outside reset.
`define SQM_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("sqm assertion failed");

`endif

@@ rtl/sqm_pkg.sv @@
// Types and codes shared by the sorted queue merge unit.
package sqm_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        OP_PUSH_FIRST  = 2'd0,
        OP_PUSH_SECOND = 2'd1,
        OP_MERGE       = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_MERGED   = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        logic    push_first;
        logic    push_second;
        logic    pop_first;
        logic    pop_second;
        logic    load_out;
        status_t out_status;
        logic    out_last;
    } cmd_t;

    typedef struct packed {
        logic first_empty;
        logic first_full;
        logic first_one;
        logic second_empty;
        logic second_full;
        logic second_one;
        logic first_less;
        logic out_valid;
    } dp_status_t;

endpackage

@@ rtl/sqm_queue.sv @@
// One bounded FIFO queue with a registered front read.
module sqm_queue #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic                             pop,
    input  logic signed [sqm_pkg::DATA_W-1:0] push_data,
    output logic signed [sqm_pkg::DATA_W-1:0] front,
    output logic                             empty,
    output logic                             full,
    output logic                             one
);

    `include "sorted_queue_merge_unit_assert.svh"

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic signed [sqm_pkg::DATA_W-1:0] mem [QUEUE_DEPTH];
    logic signed [sqm_pkg::DATA_W-1:0] front_reg;

    logic [PTR_W-1:0] head_reg, head_next, head_inc, tail, rd_addr;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] tail_sum, tail_wrap;

    always_comb
    begin
        head_inc  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
        tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    tail_sum - SUM_W'(QUEUE_DEPTH) : tail_sum;
        tail      = tail_wrap[PTR_W-1:0];
        head_next = pop ? head_inc : head_reg;
        rd_addr   = head_next;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail] <= push_data;
        end
        front_reg <= mem[rd_addr];
    end

    assign front = front_reg;
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign one   = (count_reg == CNT_W'(1));

    `SQM_ASSERT_IMP(a_push_not_full, clk, rst_n, push, !full)
    `SQM_ASSERT_IMP(a_pop_not_empty, clk, rst_n, pop, !empty && !push)
    `SQM_ASSERT_NXT(a_head_holds, clk, rst_n, !pop, $stable(head_reg))

endmodule

@@ rtl/sqm_datapath.sv @@
// Datapath: two queues, front compare and the result register.
module sqm_datapath #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sqm_pkg::cmd_t                     cmd,
    input  logic signed [sqm_pkg::DATA_W-1:0] push_data,
    output sqm_pkg::dp_status_t               dp_status,
    output logic                              out_valid,
    output logic [1:0]                        out_status,
    output logic signed [sqm_pkg::DATA_W-1:0] out_value,
    output logic                              out_last,
    input  logic                              out_stall
);

    logic signed [sqm_pkg::DATA_W-1:0] front_first, front_second, sel_value;
    logic first_empty, first_full, first_one;
    logic second_empty, second_full, second_one;

    logic                              valid_reg, valid_next;
    sqm_pkg::status_t                  status_reg;
    logic signed [sqm_pkg::DATA_W-1:0] value_reg;
    logic                              last_reg;

    sqm_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd.push_first),
        .pop       (cmd.pop_first),
        .push_data (push_data),
        .front     (front_first),
        .empty     (first_empty),
        .full      (first_full),
        .one       (first_one)
    );

    sqm_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd.push_second),
        .pop       (cmd.pop_second),
        .push_data (push_data),
        .front     (front_second),
        .empty     (second_empty),
        .full      (second_full),
        .one       (second_one)
    );

    always_comb
    begin
        if (cmd.pop_first)
        begin
            sel_value = front_first;
        end
        else if (cmd.pop_second)
        begin
            sel_value = front_second;
        end
        else
        begin
            sel_value = '0;
        end
        valid_next = valid_reg;
        if (cmd.load_out)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_reg <= cmd.out_status;
            value_reg  <= sel_value;
            last_reg   <= cmd.out_last;
        end
    end

    assign dp_status.first_empty  = first_empty;
    assign dp_status.first_full   = first_full;
    assign dp_status.first_one    = first_one;
    assign dp_status.second_empty = second_empty;
    assign dp_status.second_full  = second_full;
    assign dp_status.second_one   = second_one;
    assign dp_status.first_less   = (front_first < front_second);
    assign dp_status.out_valid    = valid_reg;

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_value  = value_reg;
    assign out_last   = last_reg;

endmodule

@@ rtl/sqm_ctrl.sv @@
// Controller: decodes items and sequences the merge drain.
module sqm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          opcode,
    input  logic                out_stall,
    input  sqm_pkg::dp_status_t dp_status,
    output sqm_pkg::cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_free, accept, take_first, last_pop;

    always_comb
    begin
        out_free   = !dp_status.out_valid || !out_stall;
        in_stall   = !((state_reg == S_IDLE) && out_free);
        accept     = in_valid && !in_stall;
        state_next = state_reg;
        cmd        = '0;
        cmd.out_status = sqm_pkg::ST_ACCEPTED;
        take_first = dp_status.second_empty ||
                     (!dp_status.first_empty && dp_status.first_less);
        last_pop   = take_first ?
                     (dp_status.first_one && dp_status.second_empty) :
                     (dp_status.second_one && dp_status.first_empty);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        sqm_pkg::OP_PUSH_FIRST:
                        begin
                            cmd.push_first = !dp_status.first_full;
                            cmd.load_out   = 1'b1;
                            cmd.out_last   = 1'b1;
                            cmd.out_status = dp_status.first_full ?
                                             sqm_pkg::ST_FULL : sqm_pkg::ST_ACCEPTED;
                        end
                        sqm_pkg::OP_PUSH_SECOND:
                        begin
                            cmd.push_second = !dp_status.second_full;
                            cmd.load_out    = 1'b1;
                            cmd.out_last    = 1'b1;
                            cmd.out_status  = dp_status.second_full ?
                                              sqm_pkg::ST_FULL : sqm_pkg::ST_ACCEPTED;
                        end
                        sqm_pkg::OP_MERGE:
                        begin
                            if (dp_status.first_empty && dp_status.second_empty)
                            begin
                                cmd.load_out   = 1'b1;
                                cmd.out_last   = 1'b1;
                                cmd.out_status = sqm_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.pop_first  = take_first;
                    cmd.pop_second = !take_first;
                    cmd.load_out   = 1'b1;
                    cmd.out_last   = last_pop;
                    cmd.out_status = sqm_pkg::ST_MERGED;
                    if (last_pop)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/sorted_queue_merge_unit.sv @@
// Top level: two sorted queues with push and two-way merge.
// Push: result registered and shown the next cycle; one push per cycle while the output is not stalled.
// Merge of N stored values: input stalls after the transfer while the queue memories
// are read, then one value per cycle while the output is not stalled.
// Reset (async, active low) empties both queues and drops any pending result;
// queue memories are not cleared.
module sorted_queue_merge_unit #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        opcode,
    input  logic signed [sqm_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic signed [sqm_pkg::DATA_W-1:0] merged_value,
    output logic                              last
);

    sqm_pkg::cmd_t       cmd;
    sqm_pkg::dp_status_t dp_status;

    sqm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_stall (out_stall),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    sqm_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_data  (value),
        .dp_status  (dp_status),
        .out_valid  (out_valid),
        .out_status (status),
        .out_value  (merged_value),
        .out_last   (last),
        .out_stall  (out_stall)
    );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the sorted queue merge unit: pushes, merges, full queues, stalls.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        sqm_pkg::status_t   status;
        logic signed [31:0] value;
        logic               last;
    } merge_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         opcode = sqm_pkg::OP_PUSH_FIRST;
    logic signed [31:0] value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] merged_value;
    logic               last;

    logic signed [31:0] first_queue[$];
    logic signed [31:0] second_queue[$];
    merge_result_t      expected_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int pushes_accepted = 0;
    int pushes_rejected = 0;
    int merges = 0;
    int values_merged = 0;
    int empty_merges = 0;
    int ignored_items = 0;

    sorted_queue_merge_unit #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .merged_value(merged_value),
        .last(last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic predict_results(logic [1:0] op, logic signed [31:0] val);
        merge_result_t r;
        r.value = '0;
        r.last = 1'b1;
        case (op) inside
            sqm_pkg::OP_PUSH_FIRST, sqm_pkg::OP_PUSH_SECOND:
            begin
                if (op == sqm_pkg::OP_PUSH_FIRST ? first_queue.size() < DEPTH
                                                 : second_queue.size() < DEPTH)
                begin
                    if (op == sqm_pkg::OP_PUSH_FIRST)
                        first_queue.push_back(val);
                    else
                        second_queue.push_back(val);
                    r.status = sqm_pkg::ST_ACCEPTED;
                    pushes_accepted++;
                end
                else
                begin
                    r.status = sqm_pkg::ST_FULL;
                    pushes_rejected++;
                end
                expected_results.push_back(r);
            end
            sqm_pkg::OP_MERGE:
            begin
                merges++;
                if (first_queue.size() == 0 && second_queue.size() == 0)
                begin
                    r.status = sqm_pkg::ST_EMPTY;
                    expected_results.push_back(r);
                    empty_merges++;
                end
                while (first_queue.size() != 0 || second_queue.size() != 0)
                begin
                    r.status = sqm_pkg::ST_MERGED;
                    if (first_queue.size() != 0 && (second_queue.size() == 0 ||
                        first_queue[0] < second_queue[0]))
                        r.value = first_queue.pop_front();
                    else
                        r.value = second_queue.pop_front();
                    r.last = (first_queue.size() == 0 && second_queue.size() == 0);
                    expected_results.push_back(r);
                    values_merged++;
                end
            end
            default:
                ignored_items++;
        endcase
    endtask

    task automatic send_item(logic [1:0] op, logic signed [31:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_results(op, val);
    endtask

    always @(posedge clk)
    begin
        merge_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected transfer: status %0d merged_value %0d last %0d",
                       status, merged_value, last);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_r.status, status);
                    errors++;
                end
                if (merged_value !== exp_r.value)
                begin
                    $error("merged_value: expected %0d, actual %0d",
                           exp_r.value, merged_value);
                    errors++;
                end
                if (last !== exp_r.last)
                begin
                    $error("last: expected %0d, actual %0d", exp_r.last, last);
                    errors++;
                end
            end
        end
    end

    task automatic test_empty_merge();
        send_item(sqm_pkg::OP_MERGE, 32'sd0);
    endtask

    task automatic test_extreme_values();
        send_item(sqm_pkg::OP_PUSH_FIRST, 32'sh8000_0000);
        send_item(sqm_pkg::OP_PUSH_FIRST, -32'sd1);
        send_item(sqm_pkg::OP_PUSH_FIRST, 32'sd0);
        send_item(sqm_pkg::OP_PUSH_FIRST, 32'sh7fff_ffff);
        send_item(sqm_pkg::OP_PUSH_SECOND, 32'sh8000_0000);
        send_item(sqm_pkg::OP_PUSH_SECOND, 32'sd0);
        send_item(sqm_pkg::OP_PUSH_SECOND, 32'sd1);
        send_item(sqm_pkg::OP_PUSH_SECOND, 32'sh7fff_ffff);
        send_item(sqm_pkg::OP_MERGE, -32'sd1);
    endtask

    task automatic test_tie_order();
        send_item(sqm_pkg::OP_PUSH_FIRST, 32'sd5);
        send_item(sqm_pkg::OP_PUSH_FIRST, 32'sd5);
        send_item(sqm_pkg::OP_PUSH_SECOND, 32'sd5);
        send_item(sqm_pkg::OP_PUSH_SECOND, 32'sd9);
        send_item(sqm_pkg::OP_MERGE, 32'sd0);
    endtask

    task automatic test_unused_opcode();
        send_item(sqm_pkg::OP_PUSH_SECOND, 32'sd42);
        send_item(OP_UNUSED, 32'sh5555_aaaa);
        send_item(OP_UNUSED, 32'shffff_ffff);
        send_item(sqm_pkg::OP_MERGE, 32'sd0);
    endtask

    task automatic test_full_and_wrap();
        for (int i = 0; i < DEPTH + 2; i++)
            send_item(sqm_pkg::OP_PUSH_FIRST, $urandom);
        for (int i = 0; i < DEPTH + 1; i++)
            send_item(sqm_pkg::OP_PUSH_SECOND, $urandom);
        send_item(sqm_pkg::OP_MERGE, $urandom);
        for (int i = 0; i < 5; i++)
            send_item(i % 2 ? sqm_pkg::OP_PUSH_SECOND : sqm_pkg::OP_PUSH_FIRST, $urandom);
        send_item(sqm_pkg::OP_MERGE, $urandom);
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
        int sent;
        int burst;
        int flavor;
        int target;
        logic [1:0] op;
        logic signed [31:0] v;
        logic signed [31:0] run_first;
        logic signed [31:0] run_second;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 75)
            begin
                burst = $urandom_range(1, 40);
                flavor = $urandom_range(2);
                target = $urandom_range(3);
                run_first = int'($urandom_range(2000)) - 1000;
                run_second = int'($urandom_range(2000)) - 1000;
                for (int i = 0; i < burst; i++)
                begin
                    if (target == 1)
                        op = sqm_pkg::OP_PUSH_FIRST;
                    else if (target == 2)
                        op = sqm_pkg::OP_PUSH_SECOND;
                    else
                        op = $urandom_range(1) ? sqm_pkg::OP_PUSH_SECOND
                                               : sqm_pkg::OP_PUSH_FIRST;
                    case (flavor)
                        0: v = $urandom;
                        1: v = int'($urandom_range(6)) - 3;
                        default:
                        begin
                            if (op == sqm_pkg::OP_PUSH_FIRST)
                            begin
                                run_first += $urandom_range(4);
                                v = run_first;
                            end
                            else
                            begin
                                run_second += $urandom_range(4);
                                v = run_second;
                            end
                        end
                    endcase
                    send_item(op, v);
                    sent++;
                end
                send_item(sqm_pkg::OP_MERGE, $urandom);
                sent++;
            end
            else
            begin
                op = 2'($urandom_range(3));
                send_item(op, $urandom);
                if (op != OP_UNUSED)
                    sent++;
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_merge();
        test_extreme_values();
        test_tie_order();
        test_unused_opcode();
        test_full_and_wrap();
        test_random_traffic(0, 0, 90);
        test_random_traffic(84, 0, 90);
        test_random_traffic(0, 84, 90);
        test_random_traffic(18, 18, 90);
        test_random_traffic(0, 0, 20);

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Pushes: %0d accepted, %0d rejected full; %0d ignored opcode items.",
                 pushes_accepted, pushes_rejected, ignored_items);
        $display("Merges: %0d (%0d empty), %0d values drained, under mixed idle and stall.",
                 merges, empty_merges, values_merged);
        if (errors == 0)
            $display("** sorted_queue_merge_unit: PASSED **");
        else
            $display("** sorted_queue_merge_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("** sorted_queue_merge_unit: FAILED **");
        $finish;
    end

endmodule
